// ----- sv/pslbs_pkg.sv -----
// Shared types and constants for the pot-speed LED bounce scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package pslbs_pkg;

    // Sample geometry
    localparam int SAMPLE_COUNT = 8;
    localparam int SAMPLE_BITS  = 10;
    localparam int LANE_COUNT   = SAMPLE_COUNT / 2;
    localparam int PAIR_BITS    = SAMPLE_BITS + 1;
    localparam int AVG_SHIFT    = $clog2(SAMPLE_COUNT);
    localparam int TOTAL_BITS   = SAMPLE_BITS + AVG_SHIFT;

    // Voltage and speed constants
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE  = SAMPLE_BITS'(1023);
    localparam int                     RELOAD_MUL  = 100;
    localparam int                     RELOAD_NUM  = 102300;
    localparam int                     RELOAD_BITS = 17;
    localparam int                     DIV_SHIFT   = 10;

    // LED pattern ends
    localparam logic [7:0] PAT_LOW  = 8'h01;
    localparam logic [7:0] PAT_HIGH = 8'h80;

    // Item codes
    localparam logic CMD_ADC  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic                   cmd;
        logic [SAMPLE_BITS-1:0] sample_0;
        logic [SAMPLE_BITS-1:0] sample_1;
        logic [SAMPLE_BITS-1:0] sample_2;
        logic [SAMPLE_BITS-1:0] sample_3;
        logic [SAMPLE_BITS-1:0] sample_4;
        logic [SAMPLE_BITS-1:0] sample_5;
        logic [SAMPLE_BITS-1:0] sample_6;
        logic [SAMPLE_BITS-1:0] sample_7;
        logic [7:0]             button_events;
        logic [3:0]             switch_levels;
    } item_t;

    typedef struct packed {
        logic [7:0]             led_display;
        logic                   moved;
        logic [SAMPLE_BITS-1:0] voltage_level;
        logic                   voltage_changed;
        logic                   is_frozen;
    } result_t;

    // Non-sample part of a beat held in the lane stage
    typedef struct packed {
        logic       cmd;
        logic [7:0] button_events;
        logic [3:0] switch_levels;
    } stage_ctl_t;

    typedef logic [LANE_COUNT-1:0][PAIR_BITS-1:0] lane_sums_t;

endpackage

`default_nettype wire

// ----- sv/pot_speed_led_bounce_scanner_unit.sv -----
// Pot-speed LED bounce scanner: sample lanes plus merge/state core.
// An accepted item beat is registered in the lane stage, then in the
// result register. Throughput: one item per clock while result_stall is low;
// each stage holds one beat, and all state updates finish in the merge cycle.
// Reset (rst_n, async low): both stages empty, deadband 5, voltage and
// countdown 0, pattern 0x01, display 0, not frozen, no step pending.
`default_nettype none

module pot_speed_led_bounce_scanner_unit
    import pslbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire item_t      item,
    output logic            result_valid,
    input  wire logic       result_stall,
    output result_t         result,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_data
);

    logic                   stage_valid_reg, stage_valid_next;
    stage_ctl_t             stage_ctl_reg;
    logic                   advance;
    logic                   accept;
    lane_sums_t             lane_sums;
    logic [SAMPLE_BITS-1:0] samples [SAMPLE_COUNT];

    // Lane stage holds a beat until the core takes it
    assign item_stall = stage_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        stage_valid_next = item_stall ? stage_valid_reg : item_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_ctl_reg.cmd           <= item.cmd;
            stage_ctl_reg.button_events <= item.button_events;
            stage_ctl_reg.switch_levels <= item.switch_levels;
        end
    end

    // Sample lanes
    assign samples[0] = item.sample_0;
    assign samples[1] = item.sample_1;
    assign samples[2] = item.sample_2;
    assign samples[3] = item.sample_3;
    assign samples[4] = item.sample_4;
    assign samples[5] = item.sample_5;
    assign samples[6] = item.sample_6;
    assign samples[7] = item.sample_7;

    for (genvar g = 0; g < LANE_COUNT; g++)
    begin : g_lane
        pslbs_lane u_lane (
            .clk      (clk),
            .load     (accept),
            .sample_a (samples[2*g]),
            .sample_b (samples[2*g+1]),
            .pair_sum (lane_sums[g])
        );
    end

    // Merge and state core
    pslbs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid_reg),
        .stage_ctl    (stage_ctl_reg),
        .lane_sums    (lane_sums),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_stall (result_stall),
        .advance      (advance),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- sv/pslbs_lane.sv -----
// One sample lane: adds a pair of ADC samples and registers the sum.
// Depends on pslbs_pkg.
`default_nettype none

module pslbs_lane
    import pslbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   load,
    input  wire logic [SAMPLE_BITS-1:0] sample_a,
    input  wire logic [SAMPLE_BITS-1:0] sample_b,
    output logic      [PAIR_BITS-1:0]   pair_sum
);

    logic [PAIR_BITS-1:0] pair_sum_reg;
    logic [PAIR_BITS-1:0] pair_sum_next;

    // Pair add
    always_comb
    begin
        pair_sum_next = PAIR_BITS'(sample_a) + PAIR_BITS'(sample_b);
    end

    // Payload register, loaded on an accepted beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pair_sum_reg <= pair_sum_next;
        end
    end

    assign pair_sum = pair_sum_reg;

endmodule

`default_nettype wire

// ----- sv/pslbs_core.sv -----
// Merge of the lane sums and the scanner state: voltage filter, speed
// countdown, freeze flag and LED bounce, plus the result register.
// Depends on pslbs_pkg.
`default_nettype none

module pslbs_core
    import pslbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       stage_valid,
    input  wire stage_ctl_t stage_ctl,
    input  wire lane_sums_t lane_sums,
    input  wire logic       cfg_we,
    input  wire logic [5:0] cfg_data,
    input  wire logic       result_stall,
    output logic            advance,
    output logic            result_valid,
    output result_t         result
);

    logic [5:0]             deadband_reg, deadband_next;
    logic [SAMPLE_BITS-1:0] voltage_reg, voltage_next;
    logic [7:0]             countdown_reg, countdown_next;
    logic                   pending_reg, pending_next;
    logic                   frozen_reg, frozen_next;
    logic [7:0]             scan_reg, scan_next;
    logic                   left_reg, left_next;
    logic [7:0]             shown_reg, shown_next;
    logic                   result_valid_reg, result_valid_next;
    result_t                result_reg, result_next;

    logic                   fire;
    logic [TOTAL_BITS-1:0]  total;
    logic [SAMPLE_BITS-1:0] avg;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS:0]   avg_plus_db;
    logic                   adc_update;
    logic [RELOAD_BITS-1:0] reload_num;
    logic [6:0]             quo_est;
    logic [SAMPLE_BITS:0]   rem_est;
    logic [7:0]             reload;
    logic                   toggle_a;
    logic                   toggle_b;
    logic                   pend_mid;
    logic                   frz_mid;
    logic                   left_mid;
    logic                   changed;
    logic                   step;

    // Output stage takes a beat when empty or being drained
    assign advance = !result_valid_reg || !result_stall;
    assign fire    = stage_valid && advance;

    // Merge the lane sums and average
    always_comb
    begin
        total = '0;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            total = total + TOTAL_BITS'(lane_sums[i]);
        end
        avg = total[TOTAL_BITS-1:AVG_SHIFT];
    end

    // Deadband filter with end clamping
    always_comb
    begin
        diff        = (avg >= voltage_reg) ? (avg - voltage_reg) : (voltage_reg - avg);
        avg_plus_db = (SAMPLE_BITS+1)'(avg) + (SAMPLE_BITS+1)'(deadband_reg);
        adc_update  = (stage_ctl.cmd == CMD_ADC) && (diff >= SAMPLE_BITS'(deadband_reg));
    end

    // Countdown reload (102300 - 100*v) / 1023, one correction step
    always_comb
    begin
        reload_num = RELOAD_BITS'(RELOAD_NUM)
                   - RELOAD_BITS'(RELOAD_BITS'(voltage_reg) * RELOAD_BITS'(RELOAD_MUL));
        quo_est    = reload_num[RELOAD_BITS-1:DIV_SHIFT];
        rem_est    = (SAMPLE_BITS+1)'(reload_num[DIV_SHIFT-1:0])
                   + (SAMPLE_BITS+1)'(quo_est);
        reload     = 8'(quo_est) + ((rem_est >= (SAMPLE_BITS+1)'(FULL_SCALE)) ? 8'd1 : 8'd0);
    end

    // Freeze toggle chains: switch on + button up, or switch off + button down
    always_comb
    begin
        toggle_a = 1'b0;
        toggle_b = 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            if (stage_ctl.switch_levels[k] ? stage_ctl.button_events[2*k+1]
                                           : stage_ctl.button_events[2*k])
            begin
                toggle_a = 1'b1;
            end
            if (stage_ctl.switch_levels[k+2] ? stage_ctl.button_events[2*k+5]
                                             : stage_ctl.button_events[2*k+4])
            begin
                toggle_b = 1'b1;
            end
        end
    end

    // Next state for one beat
    always_comb
    begin
        deadband_next     = cfg_we ? cfg_data : deadband_reg;
        voltage_next      = voltage_reg;
        countdown_next    = countdown_reg;
        pend_mid          = pending_reg;
        frz_mid           = frozen_reg;
        changed           = 1'b0;
        left_mid          = left_reg;
        step              = 1'b0;
        pending_next      = pending_reg;
        frozen_next       = frozen_reg;
        scan_next         = scan_reg;
        left_next         = left_reg;
        shown_next        = shown_reg;
        result_next       = result_reg;
        result_valid_next = advance ? stage_valid : result_valid_reg;

        if (fire)
        begin
            if (stage_ctl.cmd == CMD_ADC)
            begin
                if (adc_update)
                begin
                    changed = 1'b1;
                    if (avg_plus_db >= (SAMPLE_BITS+1)'(FULL_SCALE))
                    begin
                        voltage_next = FULL_SCALE;
                    end
                    else if (avg <= SAMPLE_BITS'(deadband_reg))
                    begin
                        voltage_next = '0;
                    end
                    else
                    begin
                        voltage_next = avg;
                    end
                end
            end
            else
            begin
                if (countdown_reg <= 8'd1)
                begin
                    pend_mid       = 1'b1;
                    countdown_next = reload;
                end
                else
                begin
                    countdown_next = countdown_reg - 8'd1;
                end
                frz_mid = frozen_reg ^ toggle_a ^ toggle_b;
            end

            // LED step
            step         = pend_mid && !frz_mid;
            pending_next = pend_mid && !step;
            frozen_next  = frz_mid;
            if (step)
            begin
                shown_next = scan_reg;
                if (scan_reg == PAT_HIGH)
                begin
                    left_mid = 1'b0;
                end
                else if (scan_reg == PAT_LOW)
                begin
                    left_mid = 1'b1;
                end
                left_next = left_mid;
                scan_next = left_mid ? {scan_reg[6:0], 1'b0} : {1'b0, scan_reg[7:1]};
            end

            result_next.led_display     = shown_next;
            result_next.moved           = step;
            result_next.voltage_level   = voltage_next;
            result_next.voltage_changed = changed;
            result_next.is_frozen       = frz_mid;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg     <= 6'd5;
            voltage_reg      <= '0;
            countdown_reg    <= '0;
            pending_reg      <= 1'b0;
            frozen_reg       <= 1'b0;
            scan_reg         <= PAT_LOW;
            left_reg         <= 1'b0;
            shown_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            deadband_reg     <= deadband_next;
            voltage_reg      <= voltage_next;
            countdown_reg    <= countdown_next;
            pending_reg      <= pending_next;
            frozen_reg       <= frozen_next;
            scan_reg         <= scan_next;
            left_reg         <= left_next;
            shown_reg        <= shown_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- test/pslbs_scan_checker.sv -----
// Result checker for the pot-speed LED bounce scanner.
// Watches the item, result and register ports, predicts every result beat
// and compares it field by field; depends on pslbs_pkg.
module pslbs_scan_checker
    import pslbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_stall,
    input  item_t      item,
    input  logic       result_valid,
    input  logic       result_stall,
    input  result_t    result,
    input  logic       cfg_we,
    input  logic [5:0] cfg_data,
    output int         fail_count,
    output int         results_due
);

    // Shadow copy of the scanner state
    logic [5:0]             dband;
    logic [SAMPLE_BITS-1:0] level;
    logic [7:0]             count;
    logic                   step_due;
    logic                   frozen;
    logic [7:0]             pattern;
    logic                   leftward;
    logic [7:0]             shown;

    result_t scan_results_due[$];
    result_t next_scan;
    int      beat_no;

    // One line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        $display("%0t: result beat %0d: %s", $time, beat_no, msg);
        fail_count++;
    endtask

    // Does one chain of switch/button pairs flip the freeze flag
    function automatic logic chain_fires(input logic [7:0] ev, input logic [3:0] sw,
                                         input int first);
        int k;
        for (k = first; k < first + 2; k++)
        begin
            if (sw[k] && ev[2*k+1])
                return 1'b1;
            if (!sw[k] && ev[2*k])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the shadow state by one item beat and form its result
    task automatic step_scanner(input item_t it, output result_t res);
        int   total;
        int   avg;
        int   diff;
        logic changed;
        logic stepped;
        changed = 1'b0;
        stepped = 1'b0;
        if (it.cmd == CMD_ADC)
        begin
            total = it.sample_0 + it.sample_1 + it.sample_2 + it.sample_3
                  + it.sample_4 + it.sample_5 + it.sample_6 + it.sample_7;
            avg  = total / SAMPLE_COUNT;
            diff = (avg >= int'(level)) ? avg - int'(level) : int'(level) - avg;
            if (diff >= int'(dband))
            begin
                changed = 1'b1;
                if (avg + int'(dband) >= int'(FULL_SCALE))
                    level = FULL_SCALE;
                else if (avg <= int'(dband))
                    level = '0;
                else
                    level = SAMPLE_BITS'(avg);
            end
        end
        else
        begin
            // countdown of 0 or 1 runs out: request a step and reload
            if (count <= 8'd1)
            begin
                step_due = 1'b1;
                count = 8'((RELOAD_NUM - RELOAD_MUL * int'(level)) / int'(FULL_SCALE));
            end
            else
                count = count - 8'd1;
            if (it.button_events != 8'h00)
            begin
                if (chain_fires(it.button_events, it.switch_levels, 0))
                    frozen = ~frozen;
                if (chain_fires(it.button_events, it.switch_levels, 2))
                    frozen = ~frozen;
            end
        end

        // take a pending step unless frozen; bounce at the ends
        if (step_due && !frozen)
        begin
            shown = pattern;
            if (pattern == PAT_HIGH)
                leftward = 1'b0;
            else if (pattern == PAT_LOW)
                leftward = 1'b1;
            pattern  = leftward ? pattern << 1 : pattern >> 1;
            step_due = 1'b0;
            stepped  = 1'b1;
        end

        res.led_display     = shown;
        res.moved           = stepped;
        res.voltage_level   = level;
        res.voltage_changed = changed;
        res.is_frozen       = frozen;
    endtask

    task automatic check_field(input string name, input logic [9:0] got,
                               input logic [9:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        beat_no++;
        if (scan_results_due.size() == 0)
        begin
            report_mismatch("result beat with no item beat outstanding");
            return;
        end
        want = scan_results_due.pop_front();
        check_field("led_display", 10'(got.led_display), 10'(want.led_display));
        check_field("moved", 10'(got.moved), 10'(want.moved));
        check_field("voltage_level", got.voltage_level, want.voltage_level);
        check_field("voltage_changed", 10'(got.voltage_changed),
                    10'(want.voltage_changed));
        check_field("is_frozen", 10'(got.is_frozen), 10'(want.is_frozen));
    endtask

    // Sample all channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dband       = 6'd5;
            level       = '0;
            count       = 8'd0;
            step_due    = 1'b0;
            frozen      = 1'b0;
            pattern     = PAT_LOW;
            leftward    = 1'b0;
            shown       = 8'h00;
            beat_no     = 0;
            fail_count  = 0;
            results_due = 0;
            scan_results_due.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result);
            if (item_valid && !item_stall)
            begin
                step_scanner(item, next_scan);
                scan_results_due.push_back(next_scan);
            end
            if (cfg_we)
                dband = cfg_data;
            results_due = scan_results_due.size();
        end
    end

endmodule

// ----- test/tb_pot_speed_led_bounce_scanner_unit.sv -----
// Testbench top for the pot-speed LED bounce scanner.
// Drives items, result stalls and deadband writes; pslbs_scan_checker does
// the prediction. Depends on pslbs_pkg and pot_speed_led_bounce_scanner_unit.
module tb_pot_speed_led_bounce_scanner_unit;
    import pslbs_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int MAX_WAIT    = 12;
    localparam int LONG_HOLD   = 80;
    localparam int FULL        = int'(FULL_SCALE);

    logic       clk = 1'b0;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    item_t      item;
    logic       result_valid;
    logic       result_stall;
    result_t    result;
    logic       cfg_we;
    logic [5:0] cfg_data;
    int         fail_count;
    int         results_due;

    int         dband_now;
    int         volt_aim;
    bit         no_gaps;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pot_speed_led_bounce_scanner_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    pslbs_scan_checker scan_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_due  (results_due)
    );

    // Random content in every field, including the ones the item ignores
    function automatic item_t filler_beat();
        logic [95:0] raw;
        item_t       it;
        raw = {$urandom(), $urandom(), $urandom()};
        it  = raw[$bits(item_t)-1:0];
        return it;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] near_sample(input int aim, input bit jitter);
        int v;
        v = aim + (jitter ? int'($urandom_range(0, 7)) : 0);
        if (v > FULL)
            v = FULL;
        return SAMPLE_BITS'(v);
    endfunction

    function automatic item_t adc_beat(input int aim, input bit jitter);
        item_t it;
        it = filler_beat();
        it.cmd      = CMD_ADC;
        it.sample_0 = near_sample(aim, jitter);
        it.sample_1 = near_sample(aim, jitter);
        it.sample_2 = near_sample(aim, jitter);
        it.sample_3 = near_sample(aim, jitter);
        it.sample_4 = near_sample(aim, jitter);
        it.sample_5 = near_sample(aim, jitter);
        it.sample_6 = near_sample(aim, jitter);
        it.sample_7 = near_sample(aim, jitter);
        return it;
    endfunction

    function automatic item_t tick_beat(input logic [7:0] ev, input logic [3:0] sw);
        item_t it;
        it = filler_beat();
        it.cmd           = CMD_TICK;
        it.button_events = ev;
        it.switch_levels = sw;
        return it;
    endfunction

    // Mostly ticks; ADC beats walk around the deadband edges or jump,
    // leaning toward high voltages so steps come often
    function automatic item_t random_beat();
        item_t it;
        int    pick;
        int    stride;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return tick_beat(($urandom_range(0, 2) == 0) ? 8'($urandom()) : 8'h00,
                             4'($urandom()));
        if (pick < 63)
        begin
            it = filler_beat();
            it.cmd = CMD_ADC;
            return it;
        end
        if (pick < 78)
        begin
            case ($urandom_range(0, 9))
                0:       volt_aim = 0;
                1:       volt_aim = FULL;
                2:       volt_aim = dband_now;
                3:       volt_aim = FULL - dband_now;
                4, 5:    volt_aim = $urandom_range(0, FULL);
                default: volt_aim = $urandom_range(980, FULL);
            endcase
        end
        else
        begin
            stride   = int'($urandom_range(0, 2 * dband_now + 2)) - dband_now - 1;
            volt_aim = volt_aim + stride;
            if (volt_aim < 0)
                volt_aim = 0;
            if (volt_aim > FULL)
                volt_aim = FULL;
        end
        return adc_beat(volt_aim, $urandom_range(0, 3) == 0);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_beat(input item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        @(negedge clk);
    endtask

    // Stop sending and wait out every outstanding result
    task automatic settle();
        item_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_deadband(input int value);
        cfg_we    <= 1'b1;
        cfg_data  <= 6'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        dband_now = value;
    endtask

    // Extremes, clamping, deadband edges and each freeze condition
    task automatic run_directed();
        item_t it;
        send_beat(tick_beat(8'h00, 4'h0));
        send_beat(adc_beat(FULL, 1'b0));
        send_beat(adc_beat(0, 1'b0));
        send_beat(adc_beat(FULL - 3, 1'b0));
        send_beat(adc_beat(3, 1'b0));
        send_beat(adc_beat(5, 1'b0));
        send_beat(adc_beat(10, 1'b0));
        send_beat(adc_beat(14, 1'b0));
        send_beat(adc_beat(15, 1'b0));
        // alternating bit patterns in the samples
        it = adc_beat(0, 1'b0);
        it.sample_0 = 10'h2AA;
        it.sample_1 = 10'h155;
        it.sample_2 = 10'h2AA;
        it.sample_3 = 10'h155;
        it.sample_4 = 10'h2AA;
        it.sample_5 = 10'h155;
        it.sample_6 = 10'h2AA;
        it.sample_7 = 10'h155;
        send_beat(it);
        it.sample_0 = 10'h155;
        it.sample_1 = 10'h2AA;
        it.sample_6 = 10'h155;
        it.sample_7 = 10'h2AA;
        send_beat(it);
        // average that truncates
        it.sample_0 = 10'd1000;
        it.sample_1 = 10'd1001;
        it.sample_2 = 10'd1002;
        it.sample_3 = 10'd1003;
        it.sample_4 = 10'd1004;
        it.sample_5 = 10'd1005;
        it.sample_6 = 10'd1006;
        it.sample_7 = 10'd1007;
        send_beat(it);
        // each switch/button condition of both chains
        send_beat(tick_beat(8'h02, 4'h1));
        send_beat(tick_beat(8'h01, 4'h0));
        send_beat(tick_beat(8'h08, 4'h2));
        send_beat(tick_beat(8'h04, 4'h0));
        send_beat(tick_beat(8'h20, 4'h4));
        send_beat(tick_beat(8'h10, 4'h0));
        send_beat(tick_beat(8'h80, 4'h8));
        send_beat(tick_beat(8'h40, 4'h0));
        send_beat(tick_beat(8'hFF, 4'hF));
        send_beat(tick_beat(8'hFF, 4'h0));
        send_beat(tick_beat(8'h01, 4'h1));
        send_beat(tick_beat(8'h00, 4'hF));
    endtask

    // Item side and verdict
    initial
    begin : sender
        int phase;
        int n;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        dband_now  = 5;
        volt_aim   = 1000;
        no_gaps    = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        run_directed();
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase == 0)
                write_deadband(0);
            else if (phase == 1)
                write_deadband(63);
            else
                write_deadband($urandom_range(0, 63));
            volt_aim = $urandom_range(0, FULL);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                // one mid-phase pause until the pipeline drains
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    settle();
                send_beat(random_beat());
            end
        end
        settle();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls per beat, calm stretches, two long holds
    initial
    begin : receiver
        int hold;
        int taken;
        bit steady;
        taken        = 0;
        steady       = 1'b0;
        result_stall = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (taken % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (taken == 300 || taken == 1100)
                hold = LONG_HOLD;
            else
                hold = steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
            taken++;
            @(negedge clk);
        end
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- pot_speed_led_bounce_scanner_unit.f -----
sv/pslbs_pkg.sv
sv/pslbs_lane.sv
sv/pslbs_core.sv
sv/pot_speed_led_bounce_scanner_unit.sv
test/pslbs_scan_checker.sv
test/tb_pot_speed_led_bounce_scanner_unit.sv
